### rtl/core/spmq_pkg.sv
package spmq_pkg;

	localparam int CMD_BITS    = 2;
	localparam int PRIO_BITS   = 3;
	localparam int STATUS_BITS = 2;
	localparam int COUNT_BITS  = 5;

	typedef enum logic [CMD_BITS-1:0] {
		CMD_ENQUEUE = 2'd0,
		CMD_DEQUEUE = 2'd1,
		CMD_DONE    = 2'd2
	} cmd_t;

	typedef enum logic [STATUS_BITS-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_EXEC = 1'b1
	} state_t;

	typedef struct packed {
		logic load_req;
		logic execute;
	} ctrl_cmd_t;

endpackage

### rtl/core/spmq_if.sv
interface spmq_req_if #(parameter int TAG_BITS = 16);
	logic                          valid;
	logic                          ready;
	logic [spmq_pkg::CMD_BITS-1:0]  command;
	logic [spmq_pkg::PRIO_BITS-1:0] priority_req;
	logic [TAG_BITS-1:0]           message_tag;

	modport source (output valid, command, priority_req, message_tag, input ready);
	modport sink   (input valid, command, priority_req, message_tag, output ready);
endinterface

interface spmq_rsp_if #(parameter int TAG_BITS = 16);
	logic                            valid;
	logic                            ready;
	logic [spmq_pkg::STATUS_BITS-1:0] status;
	logic [TAG_BITS-1:0]             head_tag;
	logic [spmq_pkg::PRIO_BITS-1:0]   head_priority;
	logic [spmq_pkg::COUNT_BITS-1:0]  entry_count;
	logic                            available_event;

	modport source (output valid, status, head_tag, head_priority, entry_count,
		available_event, input ready);
	modport sink   (input valid, status, head_tag, head_priority, entry_count,
		available_event, output ready);
endinterface

### rtl/core/spmq_ctrl.sv
module spmq_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_ready,
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	output spmq_pkg::ctrl_cmd_t   cmd
);
	import spmq_pkg::*;

	state_t state_q, state_d;
	logic   rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.execute) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// A finished result may still wait in the output register while the next
	// beat is taken; execution holds off until that register is free.
	always_comb begin
		state_d      = state_q;
		req_ready    = 1'b0;
		cmd.load_req = 1'b0;
		cmd.execute  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load_req = 1'b1;
					state_d      = S_EXEC;
				end
			end
			S_EXEC: begin
				if (!rsp_valid_q || rsp_ready) begin
					cmd.execute = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign rsp_valid = rsp_valid_q;

endmodule

### rtl/core/spmq_datapath.sv
module spmq_datapath #(
	parameter int QUEUE_DEPTH = 16,
	parameter int TAG_BITS    = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  spmq_pkg::ctrl_cmd_t                cmd,
	input  logic [spmq_pkg::CMD_BITS-1:0]      command,
	input  logic [spmq_pkg::PRIO_BITS-1:0]     priority_req,
	input  logic [TAG_BITS-1:0]                message_tag,
	output logic [spmq_pkg::STATUS_BITS-1:0]   status,
	output logic [TAG_BITS-1:0]                head_tag,
	output logic [spmq_pkg::PRIO_BITS-1:0]     head_priority,
	output logic [spmq_pkg::COUNT_BITS-1:0]    entry_count,
	output logic                               available_event
);
	import spmq_pkg::*;

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	// Captured request beat
	logic [CMD_BITS-1:0]  cmd_s1;
	logic [PRIO_BITS-1:0] prio_s1;
	logic [TAG_BITS-1:0]  tag_s1;

	// Cell array, head at index 0
	logic [PRIO_BITS-1:0] cell_prio_q [QUEUE_DEPTH];
	logic [TAG_BITS-1:0]  cell_tag_q  [QUEUE_DEPTH];
	logic [PRIO_BITS-1:0] up_prio     [QUEUE_DEPTH];
	logic [TAG_BITS-1:0]  up_tag      [QUEUE_DEPTH];
	logic [PRIO_BITS-1:0] dn_prio     [QUEUE_DEPTH];
	logic [TAG_BITS-1:0]  dn_tag      [QUEUE_DEPTH];

	logic [CNT_W-1:0]       count_q, count_d;
	logic                   pending_q, pending_d;
	logic [QUEUE_DEPTH-1:0] lt, ins_here, shift_up;

	logic                   is_full, is_empty, do_enq, do_deq;
	logic [STATUS_BITS-1:0] res_status;
	logic [TAG_BITS-1:0]    res_tag;
	logic [PRIO_BITS-1:0]   res_prio;
	logic                   res_event;

	logic [STATUS_BITS-1:0] status_q;
	logic [TAG_BITS-1:0]    head_tag_q;
	logic [PRIO_BITS-1:0]   head_prio_q;
	logic [COUNT_BITS-1:0]  entry_count_q;
	logic                   event_q;

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			cmd_s1  <= command;
			prio_s1 <= priority_req;
			tag_s1  <= message_tag;
		end
	end

	// Entries are kept in non-increasing priority order, so the cells that
	// hold a lower priority than the request (or hold nothing) form a suffix.
	// The new entry goes to the first cell of that suffix.
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		assign lt[i] = (CNT_W'(i) >= count_q) || (cell_prio_q[i] < prio_s1);
		if (i == 0) begin : g_head
			assign ins_here[i] = lt[i];
			assign shift_up[i] = 1'b0;
			assign up_prio[i]  = prio_s1;
			assign up_tag[i]   = tag_s1;
		end else begin : g_body
			assign ins_here[i] = lt[i] && !lt[i-1];
			assign shift_up[i] = lt[i-1];
			assign up_prio[i]  = cell_prio_q[i-1];
			assign up_tag[i]   = cell_tag_q[i-1];
		end
		if (i < QUEUE_DEPTH - 1) begin : g_next
			assign dn_prio[i] = cell_prio_q[i+1];
			assign dn_tag[i]  = cell_tag_q[i+1];
		end else begin : g_tail
			assign dn_prio[i] = cell_prio_q[i];
			assign dn_tag[i]  = cell_tag_q[i];
		end
	end

	assign is_full  = (count_q == CNT_W'(QUEUE_DEPTH));
	assign is_empty = (count_q == '0);

	always_comb begin
		do_enq     = 1'b0;
		do_deq     = 1'b0;
		res_status = ST_OK;
		res_tag    = '0;
		res_prio   = '0;
		res_event  = 1'b0;
		count_d    = count_q;
		pending_d  = pending_q;
		case (cmd_s1)
			CMD_ENQUEUE: begin
				if (is_full) begin
					res_status = ST_FULL;
				end else begin
					do_enq    = 1'b1;
					count_d   = count_q + CNT_W'(1);
					pending_d = 1'b1;
					res_event = !pending_q;
				end
			end
			CMD_DEQUEUE: begin
				if (is_empty) begin
					res_status = ST_EMPTY;
				end else begin
					do_deq   = 1'b1;
					res_tag  = cell_tag_q[0];
					res_prio = cell_prio_q[0];
					count_d  = count_q - CNT_W'(1);
				end
			end
			CMD_DONE: pending_d = 1'b0;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.execute) begin
			for (int i = 0; i < QUEUE_DEPTH; i++) begin
				if (do_enq) begin
					if (ins_here[i]) begin
						cell_prio_q[i] <= prio_s1;
						cell_tag_q[i]  <= tag_s1;
					end else if (shift_up[i]) begin
						cell_prio_q[i] <= up_prio[i];
						cell_tag_q[i]  <= up_tag[i];
					end
				end else if (do_deq) begin
					cell_prio_q[i] <= dn_prio[i];
					cell_tag_q[i]  <= dn_tag[i];
				end
			end
			status_q      <= res_status;
			head_tag_q    <= res_tag;
			head_prio_q   <= res_prio;
			entry_count_q <= COUNT_BITS'(count_d);
			event_q       <= res_event;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			pending_q <= 1'b0;
		end else if (cmd.execute) begin
			count_q   <= count_d;
			pending_q <= pending_d;
		end
	end

	assign status          = status_q;
	assign head_tag        = head_tag_q;
	assign head_priority   = head_prio_q;
	assign entry_count     = entry_count_q;
	assign available_event = event_q;

endmodule

### rtl/core/stable_priority_message_queue_core.sv
// Sequence: the controller captures an accepted request beat, then inserts
// or removes the entry and registers the response beat as valid; a new
// request is taken only once the previous one has executed, and a response
// not yet taken stalls only the execute step.
// Reset: arst_n clears the entry count, the pending flag and the handshake
// state at once; the entry cells are not cleared and are read only when held.
module stable_priority_message_queue_core #(
	parameter int QUEUE_DEPTH = 16,
	parameter int TAG_BITS    = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	spmq_req_if.sink          req,
	spmq_rsp_if.source        rsp
);
	import spmq_pkg::*;

	ctrl_cmd_t ctrl_cmd;
	logic      req_ready;
	logic      rsp_valid;

	spmq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp.ready),
		.cmd       (ctrl_cmd)
	);

	spmq_datapath #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.TAG_BITS    (TAG_BITS)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (ctrl_cmd),
		.command         (req.command),
		.priority_req    (req.priority_req),
		.message_tag     (req.message_tag),
		.status          (rsp.status),
		.head_tag        (rsp.head_tag),
		.head_priority   (rsp.head_priority),
		.entry_count     (rsp.entry_count),
		.available_event (rsp.available_event)
	);

	assign req.ready = req_ready;
	assign rsp.valid = rsp_valid;

endmodule

### rtl/core/spmq_checker.sv
module spmq_checker #(
	parameter int QUEUE_DEPTH = 16,
	parameter int TAG_BITS    = 16
) (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             rsp_valid,
	input logic                             rsp_ready,
	input logic [spmq_pkg::STATUS_BITS-1:0] status,
	input logic [TAG_BITS-1:0]              head_tag,
	input logic [spmq_pkg::PRIO_BITS-1:0]   head_priority,
	input logic [spmq_pkg::COUNT_BITS-1:0]  entry_count,
	input logic                             available_event
);
	import spmq_pkg::*;

	// A stalled response beat keeps its contents.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(head_tag)
			&& $stable(head_priority) && $stable(entry_count) && $stable(available_event))
		else $error("response beat changed while stalled");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == ST_EMPTY |-> entry_count == '0 && head_tag == '0
			&& head_priority == '0 && !available_event)
		else $error("empty dequeue response is inconsistent");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == ST_FULL |-> head_tag == '0 && head_priority == '0
			&& !available_event)
		else $error("rejected enqueue response is inconsistent");

	a_event: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && available_event |-> status == ST_OK && head_tag == '0
			&& head_priority == '0)
		else $error("availability event outside a successful enqueue");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (status == ST_OK || status == ST_EMPTY || status == ST_FULL)
			&& int'(entry_count) <= QUEUE_DEPTH)
		else $error("response carries an impossible status or count");

endmodule

bind stable_priority_message_queue_core spmq_checker #(
	.QUEUE_DEPTH (QUEUE_DEPTH),
	.TAG_BITS    (TAG_BITS)
) u_spmq_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.status          (rsp.status),
	.head_tag        (rsp.head_tag),
	.head_priority   (rsp.head_priority),
	.entry_count     (rsp.entry_count),
	.available_event (rsp.available_event)
);

### verif/stable_priority_message_queue_core_test.sv
`timescale 1ns / 100ps

import spmq_pkg::*;

localparam int QDEPTH = 16;
localparam int TAG_W  = 16;

// The command field is two bits wide; its fourth value is a no-op.
localparam logic [CMD_BITS-1:0] CMD_NOP = 2'd3;

typedef struct packed {
	logic [STATUS_BITS-1:0] status;
	logic [TAG_W-1:0]       head_tag;
	logic [PRIO_BITS-1:0]   head_priority;
	logic [COUNT_BITS-1:0]  entry_count;
	logic                   available_event;
} queue_reply_t;

class queue_scoreboard;
	logic [PRIO_BITS-1:0] prio_cells[QDEPTH];
	logic [TAG_W-1:0]     tag_cells[QDEPTH];
	int                   held;
	bit                   notify_pending;
	queue_reply_t         expected_replies[$];
	int                   mismatches;

	function new();
		held = 0;
		notify_pending = 1'b0;
		mismatches = 0;
	endfunction

	// Applies one accepted request beat to the shadow queue and files the reply.
	function void apply_command(logic [CMD_BITS-1:0] cmd, logic [PRIO_BITS-1:0] prio,
		logic [TAG_W-1:0] tag);
		queue_reply_t r;
		int pos;
		r = '0;
		r.status = ST_OK;
		if (cmd == CMD_ENQUEUE) begin
			if (held >= QDEPTH) begin
				r.status = ST_FULL;
			end else begin
				// Stable insert: skip past every entry of equal or higher priority.
				pos = 0;
				while (pos < held && prio_cells[pos] >= prio)
					pos++;
				for (int i = held; i > pos; i--) begin
					prio_cells[i] = prio_cells[i-1];
					tag_cells[i]  = tag_cells[i-1];
				end
				prio_cells[pos] = prio;
				tag_cells[pos]  = tag;
				held++;
				if (!notify_pending) begin
					notify_pending = 1'b1;
					r.available_event = 1'b1;
				end
			end
		end else if (cmd == CMD_DEQUEUE) begin
			if (held == 0) begin
				r.status = ST_EMPTY;
			end else begin
				r.head_tag      = tag_cells[0];
				r.head_priority = prio_cells[0];
				for (int i = 1; i < held; i++) begin
					prio_cells[i-1] = prio_cells[i];
					tag_cells[i-1]  = tag_cells[i];
				end
				held--;
			end
		end else if (cmd == CMD_DONE) begin
			notify_pending = 1'b0;
		end
		r.entry_count = held[COUNT_BITS-1:0];
		expected_replies.push_back(r);
	endfunction

	function void check_reply(queue_reply_t got);
		queue_reply_t want;
		bit bad;
		if (expected_replies.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: reply beat with none expected: status=%0d tag=%h prio=%0d count=%0d event=%0d",
					$realtime, got.status, got.head_tag, got.head_priority, got.entry_count,
					got.available_event);
			return;
		end
		want = expected_replies.pop_front();
		bad = (got.status !== want.status) || (got.head_tag !== want.head_tag) ||
			(got.head_priority !== want.head_priority) ||
			(got.entry_count !== want.entry_count) ||
			(got.available_event !== want.available_event);
		if (bad) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("%0t: reply mismatch", $realtime);
				$display("  expected status=%0d tag=%h prio=%0d count=%0d event=%0d",
					want.status, want.head_tag, want.head_priority, want.entry_count,
					want.available_event);
				$display("  actual   status=%0d tag=%h prio=%0d count=%0d event=%0d",
					got.status, got.head_tag, got.head_priority, got.entry_count,
					got.available_event);
			end
		end
	endfunction

	function int outstanding();
		return expected_replies.size();
	endfunction
endclass

module stable_priority_message_queue_core_test;

	localparam int STALL_LIMIT = 5000;

	logic clk;
	logic arst_n;
	int   tx_idle_pct;
	int   rx_idle_pct;
	int   quiet_cycles;

	queue_scoreboard book;

	spmq_req_if #(.TAG_BITS(TAG_W)) req_ch();
	spmq_rsp_if #(.TAG_BITS(TAG_W)) rsp_ch();

	stable_priority_message_queue_core #(
		.QUEUE_DEPTH(QDEPTH),
		.TAG_BITS(TAG_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Reply side: check the beat seen at this edge, then pick the next ready.
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready)
			book.check_reply({rsp_ch.status, rsp_ch.head_tag, rsp_ch.head_priority,
				rsp_ch.entry_count, rsp_ch.available_event});
		rsp_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
	end

	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_command(input logic [CMD_BITS-1:0] cmd,
		input logic [PRIO_BITS-1:0] prio, input logic [TAG_W-1:0] tag);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid        <= 1'b1;
		req_ch.command      <= cmd;
		req_ch.priority_req <= prio;
		req_ch.message_tag  <= tag;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		book.apply_command(cmd, prio, tag);
	endtask

	// Bursts of forty beats share an enqueue bias so the queue swings between
	// empty and full; some bursts use only two priority levels to force ties.
	task automatic send_random(input int count);
		int enq_pct;
		int roll;
		bit two_levels;
		logic [PRIO_BITS-1:0] lo_level, hi_level, prio;
		logic [CMD_BITS-1:0] cmd;
		enq_pct = 50;
		two_levels = 1'b0;
		lo_level = '0;
		hi_level = '0;
		for (int i = 0; i < count; i++) begin
			if (i % 40 == 0) begin
				enq_pct    = $urandom_range(15, 85);
				two_levels = 1'($urandom_range(0, 1));
				lo_level   = PRIO_BITS'($urandom_range(0, 7));
				hi_level   = PRIO_BITS'($urandom_range(0, 7));
			end
			roll = $urandom_range(0, 99);
			if (roll < 4)
				cmd = CMD_NOP;
			else if (roll < 12)
				cmd = CMD_DONE;
			else if ($urandom_range(0, 99) < enq_pct)
				cmd = CMD_ENQUEUE;
			else
				cmd = CMD_DEQUEUE;
			if (two_levels)
				prio = $urandom_range(0, 1) ? hi_level : lo_level;
			else
				prio = PRIO_BITS'($urandom_range(0, 7));
			send_command(cmd, prio, TAG_W'($urandom));
		end
	endtask

	initial begin
		book = new();
		tx_idle_pct = 36;
		rx_idle_pct = 88;
		arst_n              <= 1'b0;
		req_ch.valid        <= 1'b0;
		req_ch.command      <= CMD_ENQUEUE;
		req_ch.priority_req <= '0;
		req_ch.message_tag  <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_command(CMD_DEQUEUE, 3'd7, 16'hffff);
		send_command(CMD_NOP, 3'd7, 16'hffff);
		send_command(CMD_DONE, 3'd0, 16'h0000);
		// Fill to the top with mixed and repeated levels.
		for (int i = 0; i < QDEPTH; i++)
			send_command(CMD_ENQUEUE, PRIO_BITS'((i * 5 + 3) % 8),
				(i == 0) ? 16'h0000 : (i == 1) ? 16'hffff : TAG_W'($urandom));
		send_command(CMD_ENQUEUE, 3'd7, 16'hbeef);
		send_command(CMD_DONE, 3'd0, 16'h0000);
		send_command(CMD_DEQUEUE, 3'd0, 16'h0000);
		send_command(CMD_DEQUEUE, 3'd0, 16'h0000);
		send_command(CMD_ENQUEUE, 3'd0, 16'h5a5a);

		send_random(317);
		tx_idle_pct = 88;
		rx_idle_pct = 36;
		send_random(317);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		send_random(316);
		@(posedge clk);
		req_ch.valid <= 1'b0;

		while (book.outstanding() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (book.mismatches == 0 && book.outstanding() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
